[sv/kctc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package kctc_pkg;

    localparam int KeyW    = 4;
    localparam int MinW    = 7;
    localparam int SecW    = 6;
    localparam int CountW  = 13;
    localparam int AngleW  = 7;
    localparam int DigitsW = 2;
    localparam int PowerW  = 2;
    localparam int OutDataW = 48;

    localparam logic [KeyW-1:0] KEY_A    = 4'd10;
    localparam logic [KeyW-1:0] KEY_STAR = 4'd14;
    localparam logic [KeyW-1:0] KEY_HASH = 4'd15;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [PowerW-1:0]  POWER_RESET = 2'd2;
    localparam logic [AngleW-1:0]  IDLE_ANGLE  = 7'd60;
    localparam logic [SecW-1:0]    SEC_MAX     = 6'd59;
    localparam logic [DigitsW-1:0] DIGITS_NONE = 2'd0;
    localparam logic [DigitsW-1:0] DIGITS_ONE  = 2'd1;
    localparam logic [DigitsW-1:0] DIGITS_TWO  = 2'd2;

    typedef enum logic [1:0] {
        PH_MIN = 2'd0,
        PH_SEC = 2'd1,
        PH_POW = 2'd2,
        PH_RUN = 2'd3
    } phase_t;

    typedef struct packed {
        logic              finished;
        logic              rejected;
        logic [AngleW-1:0] angle;
        logic              heater_on;
        logic [CountW-1:0] remaining;
        logic              power_shown;
        logic [PowerW-1:0] power_level;
        logic [DigitsW-1:0] sec_digits;
        logic [SecW-1:0]   seconds;
        logic [DigitsW-1:0] min_digits;
        logic [MinW-1:0]   minutes;
        phase_t            phase;
    } result_t;

    // servo angle per power level while running
    function automatic logic [AngleW-1:0] power_angle(input logic [PowerW-1:0] lvl);
        logic [AngleW-1:0] a;
        case (lvl)
            2'd0:    a = 7'd0;
            2'd1:    a = 7'd30;
            2'd2:    a = 7'd60;
            2'd3:    a = 7'd90;
            default: a = 7'd0;
        endcase
        return a;
    endfunction

    // divide by ten for values below 128 by reciprocal multiply
    function automatic logic [MinW-1:0] div10(input logic [MinW-1:0] v);
        logic [17:0] p;
        p = {11'd0, v} * 18'd205;
        return p[17:11];
    endfunction

endpackage
`default_nettype wire

[sv/kctc_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
module kctc_engine (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    advance,
    input  wire logic                    op,
    input  wire logic [kctc_pkg::KeyW-1:0] key_code,
    output kctc_pkg::result_t            result
);
    import kctc_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [MinW-1:0]     minutes_reg, minutes_next;
    logic [DigitsW-1:0]  min_cnt_reg, min_cnt_next;
    logic [SecW-1:0]     seconds_reg, seconds_next;
    logic [DigitsW-1:0]  sec_cnt_reg, sec_cnt_next;
    logic [PowerW-1:0]   power_reg, power_next;
    logic                shown_reg, shown_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic                rejected, finished;

    logic                is_key, is_digit, is_star, is_hash;
    logic [MinW-1:0]     min_append;
    logic [MinW-1:0]     sec_append;
    logic [CountW-1:0]   load_value;

    assign is_key   = (op == OP_KEY);
    assign is_digit = (key_code < KEY_A);
    assign is_star  = (key_code == KEY_STAR);
    assign is_hash  = (key_code == KEY_HASH);

    assign min_append = 7'(minutes_reg * 7'd10) + {3'd0, key_code};
    assign sec_append = 7'({1'b0, seconds_reg} * 7'd10) + {3'd0, key_code};
    assign load_value = 13'(minutes_reg * 13'd60) + {7'd0, seconds_reg};

    // phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_MIN:
            begin
                if (is_key && is_hash)
                    phase_next = PH_SEC;
            end
            PH_SEC:
            begin
                if (is_key && is_hash)
                    phase_next = PH_POW;
                else if (is_key && is_star && sec_cnt_reg == DIGITS_NONE)
                    phase_next = PH_MIN;
            end
            PH_POW:
            begin
                if (is_key && is_hash)
                    phase_next = PH_RUN;
                else if (is_key && is_star && !shown_reg)
                    phase_next = PH_SEC;
            end
            PH_RUN:
            begin
                if ((is_key && is_star) || (!is_key && count_reg == '0))
                    phase_next = PH_MIN;
            end
            default: phase_next = PH_MIN;
        endcase
    end

    // entry values and countdown
    always_comb
    begin
        minutes_next = minutes_reg;
        min_cnt_next = min_cnt_reg;
        seconds_next = seconds_reg;
        sec_cnt_next = sec_cnt_reg;
        power_next   = power_reg;
        shown_next   = shown_reg;
        count_next   = count_reg;
        rejected     = 1'b0;
        finished     = 1'b0;
        case (phase_reg)
            PH_MIN:
            begin
                if (is_key)
                begin
                    seconds_next = '0;
                    sec_cnt_next = DIGITS_NONE;
                    if (is_hash)
                        min_cnt_next = DIGITS_TWO;
                    else if (is_star)
                    begin
                        if (min_cnt_reg == DIGITS_TWO)
                        begin
                            min_cnt_next = DIGITS_ONE;
                            minutes_next = div10(minutes_reg);
                        end
                        else if (min_cnt_reg == DIGITS_ONE)
                        begin
                            min_cnt_next = DIGITS_NONE;
                            minutes_next = '0;
                        end
                    end
                    else if (is_digit)
                    begin
                        if (minutes_reg >= 7'd10)
                            rejected = 1'b1;
                        else
                        begin
                            minutes_next = min_append;
                            min_cnt_next = (min_append >= 7'd10) ? DIGITS_TWO : DIGITS_ONE;
                        end
                    end
                end
            end
            PH_SEC:
            begin
                if (is_key)
                begin
                    if (is_hash)
                        sec_cnt_next = DIGITS_TWO;
                    else if (is_star)
                    begin
                        if (sec_cnt_reg == DIGITS_TWO)
                        begin
                            sec_cnt_next = DIGITS_ONE;
                            seconds_next = SecW'(div10({1'b0, seconds_reg}));
                        end
                        else if (sec_cnt_reg == DIGITS_ONE)
                        begin
                            sec_cnt_next = DIGITS_NONE;
                            seconds_next = '0;
                        end
                    end
                    else if (is_digit && seconds_reg < 6'd10)
                    begin
                        if (sec_append >= 7'd60)
                            seconds_next = SEC_MAX;
                        else
                            seconds_next = sec_append[SecW-1:0];
                        sec_cnt_next = (sec_append >= 7'd10) ? DIGITS_TWO : DIGITS_ONE;
                    end
                end
            end
            PH_POW:
            begin
                if (is_key)
                begin
                    if (is_hash)
                        count_next = load_value;
                    else if (is_star)
                        shown_next = 1'b0;
                    else if (!is_digit)
                    begin
                        power_next = PowerW'(key_code - KEY_A);
                        shown_next = 1'b1;
                    end
                end
            end
            PH_RUN:
            begin
                if ((is_key && is_star) || (!is_key && count_reg == '0))
                begin
                    finished     = 1'b1;
                    minutes_next = '0;
                    min_cnt_next = DIGITS_NONE;
                    seconds_next = '0;
                    sec_cnt_next = DIGITS_NONE;
                    count_next   = '0;
                end
                else if (!is_key)
                    count_next = count_reg - 13'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MIN;
            minutes_reg <= '0;
            min_cnt_reg <= DIGITS_NONE;
            seconds_reg <= '0;
            sec_cnt_reg <= DIGITS_NONE;
            power_reg   <= POWER_RESET;
            shown_reg   <= 1'b0;
            count_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            minutes_reg <= minutes_next;
            min_cnt_reg <= min_cnt_next;
            seconds_reg <= seconds_next;
            sec_cnt_reg <= sec_cnt_next;
            power_reg   <= power_next;
            shown_reg   <= shown_next;
            count_reg   <= count_next;
        end
    end

    // result word shows the state after the event
    always_comb
    begin
        result.phase       = phase_next;
        result.minutes     = minutes_next;
        result.min_digits  = min_cnt_next;
        result.seconds     = seconds_next;
        result.sec_digits  = sec_cnt_next;
        result.power_level = power_next;
        result.power_shown = shown_next;
        result.heater_on   = (phase_next == PH_RUN);
        result.remaining   = (phase_next == PH_RUN) ? count_next : '0;
        result.angle       = (phase_next == PH_RUN) ? power_angle(power_next) : IDLE_ANGLE;
        result.rejected    = rejected;
        result.finished    = finished;
    end

endmodule
`default_nettype wire

[sv/keypad_cook_timer_controller_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// keypad cook timer: each input word is a key press (tuser 0) or a one-second tick
// (tuser 1), and each one yields exactly one status word showing the state after it.
// one word is taken per clock when the output side keeps up: a word sits in the input
// register while the event logic works out the next state, then lands in the output
// register once it is empty or being read; m_axis_tvalid is that register's valid flag.
module keypad_cook_timer_controller_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // key_code[3:0], zeros
    input  wire logic        s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // phase[1:0], minutes_value[8:2],
                                             // minute_digits_shown[10:9],
                                             // seconds_value[16:11],
                                             // second_digits_shown[18:17],
                                             // power_level[20:19], power_shown[21],
                                             // remaining_seconds[34:22], heater_on[35],
                                             // power_servo_angle[42:36],
                                             // entry_rejected[43], run_finished[44], zeros
);
    import kctc_pkg::*;

    logic            in_valid_reg;
    logic            op_reg;
    logic [KeyW-1:0] key_reg;
    logic            out_valid_reg;
    result_t         out_reg;
    result_t         result;
    logic            advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg  <= s_axis_tuser;
            key_reg <= s_axis_tdata[KeyW-1:0];
        end
        if (advance)
            out_reg <= result;
    end

    kctc_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .op       (op_reg),
        .key_code (key_reg),
        .result   (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), out_reg};

endmodule
`default_nettype wire
